[rtl/heading_hold_motor_drive_defines.svh]
// assertion helpers for the heading hold motor drive
`ifndef HEADING_HOLD_MOTOR_DRIVE_DEFINES_SVH
`define HEADING_HOLD_MOTOR_DRIVE_DEFINES_SVH

// condition holds in the same cycle
`define HHMD_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("heading hold drive check failed");

// condition holds in the following cycle
`define HHMD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("heading hold drive check failed");

`endif

[rtl/hhmd_pkg.sv]
package hhmd_pkg;

  localparam int unsigned PWM_MAX = 255;

  // command codes
  localparam logic [3:0] CMD_STOP    = 4'd0;
  localparam logic [3:0] CMD_FWD     = 4'd1;
  localparam logic [3:0] CMD_REV     = 4'd2;
  localparam logic [3:0] CMD_SPIN_R  = 4'd3;
  localparam logic [3:0] CMD_SPIN_L  = 4'd4;
  localparam logic [3:0] CMD_ARC_FL  = 4'd5;
  localparam logic [3:0] CMD_ARC_FR  = 4'd6;
  localparam logic [3:0] CMD_ARC_RL  = 4'd7;
  localparam logic [3:0] CMD_ARC_RR  = 4'd8;

  // register indexes
  localparam logic [2:0] REG_START_PWM = 3'd0;
  localparam logic [2:0] REG_RAMP_STEP = 3'd1;
  localparam logic [2:0] REG_RAMP_INTV = 3'd2;
  localparam logic [2:0] REG_KP_FWD    = 3'd3;
  localparam logic [2:0] REG_KD_FWD    = 3'd4;
  localparam logic [2:0] REG_KP_REV    = 3'd5;
  localparam logic [2:0] REG_KD_REV    = 3'd6;

  localparam int unsigned IN_W  = 56;
  localparam int unsigned OUT_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL1,
    ST_MUL2,
    ST_SHAPE,
    ST_SCALE,
    ST_DRIVE
  } state_e;

  typedef struct packed {
    logic ld_in;
    logic ld_err;
    logic ld_mul1;
    logic ld_mul2;
    logic ld_shape;
    logic ld_scale;
    logic ld_drive;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

[rtl/hhmd_ctrl.sv]
module hhmd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  hhmd_pkg::stat_t stat_i,
  output logic            in_ready_o,
  output hhmd_pkg::ctrl_t ctrl_o
);

  hhmd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hhmd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      hhmd_pkg::ST_IDLE:  if (in_valid_i) state_d = hhmd_pkg::ST_ERR;
      hhmd_pkg::ST_ERR:   state_d = hhmd_pkg::ST_MUL1;
      hhmd_pkg::ST_MUL1:  state_d = hhmd_pkg::ST_MUL2;
      hhmd_pkg::ST_MUL2:  state_d = hhmd_pkg::ST_SHAPE;
      hhmd_pkg::ST_SHAPE: state_d = hhmd_pkg::ST_SCALE;
      hhmd_pkg::ST_SCALE: state_d = hhmd_pkg::ST_DRIVE;
      hhmd_pkg::ST_DRIVE: if (!stat_i.out_busy) state_d = hhmd_pkg::ST_IDLE;
      default:            state_d = hhmd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      hhmd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        ctrl_o.ld_in = in_valid_i;
      end
      hhmd_pkg::ST_ERR:   ctrl_o.ld_err   = 1'b1;
      hhmd_pkg::ST_MUL1:  ctrl_o.ld_mul1  = 1'b1;
      hhmd_pkg::ST_MUL2:  ctrl_o.ld_mul2  = 1'b1;
      hhmd_pkg::ST_SHAPE: ctrl_o.ld_shape = 1'b1;
      hhmd_pkg::ST_SCALE: ctrl_o.ld_scale = 1'b1;
      hhmd_pkg::ST_DRIVE: ctrl_o.ld_drive = !stat_i.out_busy;
      default: ;
    endcase
  end

endmodule

[rtl/hhmd_dp.sv]
module hhmd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic [hhmd_pkg::IN_W-1:0]     in_data_i,
  input  hhmd_pkg::ctrl_t               ctrl_i,
  output hhmd_pkg::stat_t               stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hhmd_pkg::OUT_W-1:0]    out_data_o
);

  localparam logic signed [35:0] ONE_DEG = 36'sd6553600;
  localparam logic signed [35:0] LIM_FWD = 36'sd294912000;
  localparam logic signed [35:0] LIM_PD  = 36'sd262144000;
  localparam logic signed [35:0] LIM_REV = 36'sd7208960000;
  localparam logic signed [35:0] HALF_Q  = 36'sd26214400;
  localparam logic [12:0]        RECIP25 = 13'd5243;

  // configuration
  logic [7:0]  start_pwm_q, ramp_step_q;
  logic [15:0] ramp_intv_q, kp_fwd_q, kd_fwd_q, kp_rev_q, kd_rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pwm_q <= 8'd10;
      ramp_step_q <= 8'd2;
      ramp_intv_q <= 16'd8;
      kp_fwd_q    <= 16'd2621;
      kd_fwd_q    <= 16'd9830;
      kp_rev_q    <= 16'd4588;
      kd_rev_q    <= 16'd9830;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hhmd_pkg::REG_START_PWM: start_pwm_q <= cfg_data_i[7:0];
        hhmd_pkg::REG_RAMP_STEP: ramp_step_q <= cfg_data_i[7:0];
        hhmd_pkg::REG_RAMP_INTV: ramp_intv_q <= cfg_data_i;
        hhmd_pkg::REG_KP_FWD:    kp_fwd_q    <= cfg_data_i;
        hhmd_pkg::REG_KD_FWD:    kd_fwd_q    <= cfg_data_i;
        hhmd_pkg::REG_KP_REV:    kp_rev_q    <= cfg_data_i;
        hhmd_pkg::REG_KD_REV:    kd_rev_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word
  logic [3:0]  cmd_q;
  logic [15:0] hdg_q;
  logic [31:0] now_q;
  logic        db_q, tb_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_in) begin
      cmd_q <= in_data_i[3:0];
      hdg_q <= in_data_i[19:4];
      now_q <= in_data_i[51:20];
      db_q  <= in_data_i[52];
      tb_q  <= in_data_i[53];
    end
  end

  // heading error with wrap and deadband
  logic [15:0]        target_q, tgt;
  logic signed [15:0] prev_q, prev_eff, e_db;
  logic [3:0]         last_cmd_q;
  logic               new_cmd, pd_cmd, is_rev;
  logic signed [17:0] raw, w1, w2;
  logic signed [15:0] e_q;
  logic signed [16:0] de_q;

  assign new_cmd  = cmd_q != last_cmd_q;
  assign pd_cmd   = (cmd_q == hhmd_pkg::CMD_FWD) || (cmd_q == hhmd_pkg::CMD_REV);
  assign is_rev   = cmd_q == hhmd_pkg::CMD_REV;
  assign tgt      = new_cmd ? hdg_q : target_q;
  assign prev_eff = new_cmd ? 16'sd0 : prev_q;
  assign raw      = $signed({2'b00, tgt}) - $signed({2'b00, hdg_q});

  always_comb begin
    w1 = raw;
    if (raw > 18'sd18000) w1 = raw - 18'sd36000;
    else if (raw < -18'sd18000) w1 = raw + 18'sd36000;
    w2 = w1;
    if (w1 > 18'sd18000) w2 = w1 - 18'sd36000;
    else if (w1 < -18'sd18000) w2 = w1 + 18'sd36000;
    e_db = (w2 > -18'sd100 && w2 < 18'sd100) ? 16'sd0 : w2[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      prev_q     <= '0;
      last_cmd_q <= hhmd_pkg::CMD_STOP;
    end else if (ctrl_i.ld_err) begin
      last_cmd_q <= cmd_q;
      if (pd_cmd) begin
        target_q <= tgt;
        prev_q   <= e_db;
      end else if (cmd_q == hhmd_pkg::CMD_STOP || cmd_q == hhmd_pkg::CMD_SPIN_R ||
                   cmd_q == hhmd_pkg::CMD_SPIN_L) begin
        prev_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_err) begin
      e_q  <= e_db;
      de_q <= {e_db[15], e_db} - {prev_eff[15], prev_eff};
    end
  end

  // shared multiplier: p term, then d term
  logic [15:0]        gain;
  logic signed [16:0] mop;
  logic signed [33:0] mul;
  logic signed [33:0] p_q;
  logic signed [35:0] acc_q;

  always_comb begin
    if (ctrl_i.ld_mul2) begin
      gain = is_rev ? kd_rev_q : kd_fwd_q;
      mop  = de_q;
    end else begin
      gain = is_rev ? kp_rev_q : kp_fwd_q;
      mop  = {e_q[15], e_q};
    end
    mul = $signed({1'b0, gain}) * mop;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_mul1) p_q <= mul;
    if (ctrl_i.ld_mul2) acc_q <= {{2{p_q[33]}}, p_q} + {{2{mul[33]}}, mul};
  end

  // clamps and step magnitude
  logic signed [35:0] cf, cfa, pdc, cr, cra, ew;
  logic [11:0]        mag_d, mag_q;
  logic               neg_d, neg_q;
  logic               big_e;

  always_comb begin
    ew    = {{20{e_q[15]}}, e_q};
    big_e = (e_q >= 16'sd35) || (e_q <= -16'sd35);
    cf = acc_q;
    if (acc_q > LIM_FWD) cf = LIM_FWD;
    else if (acc_q < -LIM_FWD) cf = -LIM_FWD;
    if (cf > -ONE_DEG && cf < ONE_DEG && big_e) cf = cf[35] ? -ONE_DEG : ONE_DEG;
    cfa = cf[35] ? -cf : cf;
    pdc = acc_q;
    if (acc_q > LIM_PD) pdc = LIM_PD;
    else if (acc_q < -LIM_PD) pdc = -LIM_PD;
    // 20*pd + 9*2^16*e
    cr = (pdc <<< 4) + (pdc <<< 2) + (ew <<< 19) + (ew <<< 16);
    if (cr > LIM_REV) cr = LIM_REV;
    else if (cr < -LIM_REV) cr = -LIM_REV;
    cra = (cr[35] ? -cr : cr) + HALF_Q;
    if (is_rev) begin
      mag_d = cra[32:21];
      neg_d = cr[35];
    end else begin
      mag_d = cfa[28:17];
      neg_d = cf[35];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_shape) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
  end

  // divide by 25 and form motor targets
  logic [24:0]        qprod;
  logic signed [10:0] s;
  logic [7:0]         tl_d, tr_d, tl_q, tr_q;
  logic               dl_d, dr_d, dl_q, dr_q, clrd_d, clrt_d, clrd_q, clrt_q;
  logic               dirl_q, dirr_q;

  function automatic logic [7:0] sat8(input logic signed [10:0] v);
    if (v < 11'sd0) return 8'd0;
    if (v > 11'sd255) return 8'd255;
    return v[7:0];
  endfunction

  assign qprod = mag_q * RECIP25;
  assign s     = neg_q ? -$signed({3'b000, qprod[24:17]}) : $signed({3'b000, qprod[24:17]});

  always_comb begin
    tl_d   = '0;
    tr_d   = '0;
    dl_d   = 1'b0;
    dr_d   = 1'b0;
    clrd_d = 1'b0;
    clrt_d = 1'b0;
    case (cmd_q)
      hhmd_pkg::CMD_STOP: begin
        clrd_d = 1'b1;
        clrt_d = 1'b1;
      end
      hhmd_pkg::CMD_FWD: begin
        clrt_d = 1'b1;
        tl_d   = sat8(11'sd242 + s);
        tr_d   = sat8(11'sd237 - s);
      end
      hhmd_pkg::CMD_REV: begin
        clrt_d = 1'b1;
        dl_d   = 1'b1;
        dr_d   = 1'b1;
        tl_d   = sat8(11'sd240 + s);
        tr_d   = sat8(11'sd247 - s);
      end
      hhmd_pkg::CMD_SPIN_R: begin
        clrd_d = 1'b1;
        dr_d   = 1'b1;
        tl_d   = tb_q ? 8'd148 : 8'd82;
        tr_d   = tb_q ? 8'd146 : 8'd80;
      end
      hhmd_pkg::CMD_SPIN_L: begin
        clrd_d = 1'b1;
        dl_d   = 1'b1;
        tl_d   = tb_q ? 8'd150 : 8'd83;
        tr_d   = tb_q ? 8'd147 : 8'd80;
      end
      hhmd_pkg::CMD_ARC_FL: begin
        clrt_d = 1'b1;
        tl_d   = db_q ? 8'd245 : 8'd204;
        tr_d   = 8'd150;
      end
      hhmd_pkg::CMD_ARC_FR: begin
        clrt_d = 1'b1;
        tl_d   = 8'd150;
        tr_d   = db_q ? 8'd250 : 8'd215;
      end
      hhmd_pkg::CMD_ARC_RL: begin
        clrt_d = 1'b1;
        dl_d   = 1'b1;
        dr_d   = 1'b1;
        tl_d   = db_q ? 8'd251 : 8'd209;
        tr_d   = 8'd150;
      end
      hhmd_pkg::CMD_ARC_RR: begin
        clrt_d = 1'b1;
        dl_d   = 1'b1;
        dr_d   = dirr_q;
        tl_d   = 8'd150;
        tr_d   = db_q ? 8'd245 : 8'd202;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_scale) begin
      tl_q   <= tl_d;
      tr_q   <= tr_d;
      dl_q   <= dl_d;
      dr_q   <= dr_d;
      clrd_q <= clrd_d;
      clrt_q <= clrt_d;
    end
  end

  // direction interlock and soft-start ramp
  logic [7:0]  dutyl_q, dutyr_q, dutyl_d, dutyr_d, ul, ur;
  logic        dirl_d, dirr_d;
  logic [31:0] rtl_q, rtr_q, rtl_d, rtr_d, el, er;
  logic        drv;

  function automatic logic [7:0] ramp_f(input logic [7:0] duty, input logic [7:0] t,
                                        input logic [7:0] start, input logic [7:0] step);
    logic [7:0] d;
    logic [8:0] up;
    d  = (duty == 8'd0 && t != 8'd0) ? ((start < t) ? start : t) : duty;
    up = {1'b0, d} + {1'b0, step};
    if (d < t) return (up > {1'b0, t}) ? t : up[7:0];
    if (d > t) return ((d - t) < step) ? t : d - step;
    return d;
  endfunction

  assign drv = (cmd_q != hhmd_pkg::CMD_STOP) && (cmd_q <= hhmd_pkg::CMD_ARC_RR);
  assign el  = now_q - rtl_q;
  assign er  = now_q - rtr_q;

  always_comb begin
    dutyl_d = dutyl_q;
    dutyr_d = dutyr_q;
    dirl_d  = dirl_q;
    dirr_d  = dirr_q;
    rtl_d   = rtl_q;
    rtr_d   = rtr_q;
    ul      = tl_q;
    ur      = tr_q;
    if (cmd_q == hhmd_pkg::CMD_STOP) begin
      dutyl_d = '0;
      dutyr_d = '0;
      dirl_d  = 1'b0;
      dirr_d  = 1'b0;
      rtl_d   = now_q;
      rtr_d   = now_q;
    end else if (drv) begin
      if (dl_q != dirl_q) begin
        if (dutyl_q != 8'd0) ul = '0;
        else dirl_d = dl_q;
      end
      if (dr_q != dirr_q) begin
        if (dutyr_q != 8'd0) ur = '0;
        else dirr_d = dr_q;
      end
      if (el >= {16'd0, ramp_intv_q}) begin
        rtl_d   = now_q;
        dutyl_d = ramp_f(dutyl_q, ul, start_pwm_q, ramp_step_q);
      end
      if (er >= {16'd0, ramp_intv_q}) begin
        rtr_d   = now_q;
        dutyr_d = ramp_f(dutyr_q, ur, start_pwm_q, ramp_step_q);
      end
    end
  end

  logic                       ovalid_q;
  logic [hhmd_pkg::OUT_W-1:0] odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dutyl_q  <= '0;
      dutyr_q  <= '0;
      dirl_q   <= 1'b0;
      dirr_q   <= 1'b0;
      rtl_q    <= '0;
      rtr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ctrl_i.ld_drive) begin
        dutyl_q  <= dutyl_d;
        dutyr_q  <= dutyr_d;
        dirl_q   <= dirl_d;
        dirr_q   <= dirr_d;
        rtl_q    <= rtl_d;
        rtr_q    <= rtr_d;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_drive) begin
      odata_q <= {4'b0000, clrt_q, clrd_q, dirr_d, dirl_d, dutyr_d, dutyl_d};
    end
  end

  assign stat_o.out_busy = ovalid_q && !out_ready_i;
  assign out_valid_o     = ovalid_q;
  assign out_data_o      = odata_q;

endmodule

[rtl/heading_hold_motor_drive.sv]
// Heading-hold motor drive. Each input word is a drive command with heading,
// millisecond time and boost flags; each produces one output word with both
// motor duties after soft-start ramping, both direction pins and the boost
// clear flags. The command walks through error, two passes of the shared
// 17x17 multiplier for the P and D terms, clamp, scale and ramp steps, one
// at a time, and a new word is taken only once its predecessor has left the
// ramp step. The next word is taken while the previous result waits in the
// output register; a stalled output holds the ramp step. Configuration is
// written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only
// while the block is idle, which the block itself does not enforce.
module heading_hold_motor_drive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cmd[3:0], heading[19:4], now_ms[51:20], drive_boost[52], turn_boost[53], zero fill
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pwm_left[7:0], pwm_right[15:8], dir_left[16], dir_right[17],
  // clear_drive_boost[18], clear_turn_boost[19], zero fill
  output logic [23:0] m_axis_tdata
);

  hhmd_pkg::ctrl_t ctrl;
  hhmd_pkg::stat_t stat;

  hhmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  hhmd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

[rtl/hhmd_checker.sv]
`include "heading_hold_motor_drive_defines.svh"

module hhmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // one word in flight at a time
  `HHMD_ASSERT_NEXT(busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a result never appears the cycle right after its word is taken
  `HHMD_ASSERT_NEXT(no_instant_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid,
                    !m_axis_tvalid)

  `HHMD_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata))

  // unused upper bits of a result stay zero
  `HHMD_ASSERT_NOW(fill_zero, m_axis_tvalid, m_axis_tdata[23:20] == 4'b0000)

endmodule

bind heading_hold_motor_drive hhmd_checker u_hhmd_checker (.*);

[sim/heading_hold_motor_drive_test.sv]
`timescale 1ns / 100ps

module heading_hold_motor_drive_test;

  localparam int unsigned LAT = 7;
  localparam logic signed [63:0] ONE_DEG = 64'sd6553600;

  // packed from the top bit down, so pwm_l lands in bits 7:0
  typedef struct packed {
    logic       clr_turn;
    logic       clr_drive;
    logic       dir_r;
    logic       dir_l;
    logic [7:0] pwm_r;
    logic [7:0] pwm_l;
  } drive_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  heading_hold_motor_drive dut (.*);

  // predictor state
  logic [7:0]  p_start_pwm, p_ramp_step;
  logic [15:0] p_ramp_intv, p_kp_f, p_kd_f, p_kp_r, p_kd_r;
  int          tgt_heading, prev_err;
  logic [3:0]  prev_cmd;
  int unsigned duty_l, duty_r;
  logic        dir_l, dir_r;
  logic [31:0] ramp_t_l, ramp_t_r;

  drive_word_t expected_q[$];
  int  error_count;
  bit  calm;
  logic [31:0] clock_ms;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("heading_hold_motor_drive_test: errors");
    $finish;
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clampl(longint v, longint lim);
    return v < -lim ? -lim : (v > lim ? lim : v);
  endfunction

  function automatic int unsigned ramp_duty(int unsigned duty, int unsigned tgt,
                                            logic [31:0] now, ref logic [31:0] stamp);
    logic [31:0] dt;
    dt = now - stamp;
    if (dt < {16'd0, p_ramp_intv}) return duty;
    stamp = now;
    if (duty == 0 && tgt > 0) duty = p_start_pwm < tgt ? p_start_pwm : tgt;
    if (duty < tgt) begin
      duty += p_ramp_step;
      if (duty > tgt) duty = tgt;
    end else if (duty > tgt) begin
      duty = (duty - tgt < p_ramp_step) ? tgt : duty - p_ramp_step;
    end
    return duty > hhmd_pkg::PWM_MAX ? hhmd_pkg::PWM_MAX : duty;
  endfunction

  function automatic void apply_drive(logic want_l, logic want_r, int tl, int tr,
                                      logic [31:0] now);
    int unsigned ul, ur;
    ul = clampi(tl, 0, 255);
    ur = clampi(tr, 0, 255);
    if (want_l != dir_l) begin
      if (duty_l > 0) ul = 0; else dir_l = want_l;
    end
    if (want_r != dir_r) begin
      if (duty_r > 0) ur = 0; else dir_r = want_r;
    end
    duty_l = ramp_duty(duty_l, ul, now, ramp_t_l);
    duty_r = ramp_duty(duty_r, ur, now, ramp_t_r);
  endfunction

  function automatic int wrapped_error(int hdg, logic [3:0] cmd);
    int e;
    if (cmd != prev_cmd) begin
      tgt_heading = hdg;
      prev_err = 0;
    end
    e = tgt_heading - hdg;
    while (e > 18000) e -= 36000;
    while (e < -18000) e += 36000;
    if (e > -100 && e < 100) e = 0;
    return e;
  endfunction

  function automatic drive_word_t predict_drive(logic [3:0] cmd, int hdg, logic [31:0] now,
                                                logic db, logic tb);
    drive_word_t w;
    int e, s;
    longint c, n, d;
    w = '0;
    d = 64'sd262144000;
    case (cmd)
      hhmd_pkg::CMD_STOP: begin
        w.clr_drive = 1; w.clr_turn = 1;
        prev_err = 0; duty_l = 0; duty_r = 0; dir_l = 0; dir_r = 0;
        ramp_t_l = now; ramp_t_r = now;
      end
      hhmd_pkg::CMD_FWD: begin
        e = wrapped_error(hdg, cmd);
        c = longint'(p_kp_f) * e + longint'(p_kd_f) * longint'(e - prev_err);
        w.clr_turn = 1;
        prev_err = e;
        c = clampl(c, 45 * ONE_DEG);
        if (c > -ONE_DEG && c < ONE_DEG && (e >= 35 || e <= -35))
          c = c >= 0 ? ONE_DEG : -ONE_DEG;
        s = int'((c * 2) / ONE_DEG);
        apply_drive(0, 0, clampi(242 + s, 0, 255), clampi(237 - s, 0, 255), now);
      end
      hhmd_pkg::CMD_REV: begin
        e = wrapped_error(hdg, cmd);
        c = 20 * (longint'(p_kp_r) * e + longint'(p_kd_r) * longint'(e - prev_err));
        w.clr_turn = 1;
        prev_err = e;
        c = clampl(c, 40 * 20 * ONE_DEG);
        c += longint'(9) * 65536 * e;
        c = clampl(c, 55 * 20 * ONE_DEG);
        n = c * 5;
        s = n >= 0 ? int'((n + d / 2) / d) : -int'((-n + d / 2) / d);
        apply_drive(1, 1, clampi(240 + s, 0, 255), clampi(247 - s, 0, 255), now);
      end
      hhmd_pkg::CMD_SPIN_R: begin
        w.clr_drive = 1; prev_err = 0;
        apply_drive(0, 1, tb ? 148 : 82, tb ? 146 : 80, now);
      end
      hhmd_pkg::CMD_SPIN_L: begin
        w.clr_drive = 1; prev_err = 0;
        apply_drive(1, 0, tb ? 150 : 83, tb ? 147 : 80, now);
      end
      hhmd_pkg::CMD_ARC_FL: begin
        w.clr_turn = 1; apply_drive(0, 0, db ? 245 : 204, 150, now);
      end
      hhmd_pkg::CMD_ARC_FR: begin
        w.clr_turn = 1; apply_drive(0, 0, 150, db ? 250 : 215, now);
      end
      hhmd_pkg::CMD_ARC_RL: begin
        w.clr_turn = 1; apply_drive(1, 1, db ? 251 : 209, 150, now);
      end
      hhmd_pkg::CMD_ARC_RR: begin
        w.clr_turn = 1; apply_drive(1, dir_r, 150, db ? 245 : 202, now);
      end
      default: ;
    endcase
    prev_cmd = cmd;
    w.pwm_l = duty_l[7:0];
    w.pwm_r = duty_r[7:0];
    w.dir_l = dir_l;
    w.dir_r = dir_r;
    return w;
  endfunction

  task automatic send_cmd(logic [3:0] cmd, logic [15:0] hdg, logic [31:0] now,
                          logic db, logic tb);
    expected_q.push_back(predict_drive(cmd, hdg, now, db, tb));
    while (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b00, tb, db, now, hdg, cmd};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      hhmd_pkg::REG_START_PWM: p_start_pwm = val[7:0];
      hhmd_pkg::REG_RAMP_STEP: p_ramp_step = val[7:0];
      hhmd_pkg::REG_RAMP_INTV: p_ramp_intv = val;
      hhmd_pkg::REG_KP_FWD:    p_kp_f = val;
      hhmd_pkg::REG_KD_FWD:    p_kd_f = val;
      hhmd_pkg::REG_KP_REV:    p_kp_r = val;
      hhmd_pkg::REG_KD_REV:    p_kd_r = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // random heading near the latched target so the controller stays in its band
  function automatic logic [15:0] near_heading(logic [15:0] base);
    int h;
    h = int'(base) + int'($urandom_range(1200)) - 600;
    if (h < 0) h += 36000;
    if (h >= 36000) h -= 36000;
    return h[15:0];
  endfunction

  task automatic send_random(int count, logic [3:0] max_cmd);
    logic [3:0] cmd;
    logic [15:0] hdg;
    for (int i = 0; i < count; i++) begin
      cmd = $urandom_range(99) < 70 ? prev_cmd : 4'($urandom_range(max_cmd));
      if (cmd > max_cmd) cmd = max_cmd;
      hdg = (($urandom_range(9) == 0) ? 16'($urandom_range(35999)) :
             near_heading(tgt_heading[15:0]));
      if ($urandom_range(49) == 0) clock_ms += $urandom;
      else clock_ms += $urandom_range(20);
      send_cmd(cmd, hdg, clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic test_directed();
    logic [3:0] c;
    clock_ms = 0;
    send_cmd(hhmd_pkg::CMD_FWD, 16'd0, 32'd0, 0, 0);
    send_cmd(hhmd_pkg::CMD_FWD, 16'd35999, 32'd9, 1, 1);
    send_cmd(hhmd_pkg::CMD_FWD, 16'd17000, 32'd20, 0, 0);
    send_cmd(hhmd_pkg::CMD_FWD, 16'd40, 32'd30, 0, 0);
    send_cmd(hhmd_pkg::CMD_FWD, 16'd35950, 32'd40, 0, 0);
    send_cmd(hhmd_pkg::CMD_REV, 16'd18000, 32'd50, 0, 0);
    send_cmd(hhmd_pkg::CMD_REV, 16'd100, 32'd60, 0, 0);
    send_cmd(hhmd_pkg::CMD_REV, 16'd20000, 32'd70, 0, 0);
    for (int i = 3; i <= 15; i++) begin
      c = i[3:0];
      send_cmd(c, 16'd1234, 32'd80 + 10 * i, i[0], i[1]);
    end
    send_cmd(hhmd_pkg::CMD_STOP, 16'd0, 32'hFFFF_FFFF, 1, 1);
    send_cmd(hhmd_pkg::CMD_ARC_RR, 16'd0, 32'd5, 1, 0);
    send_cmd(hhmd_pkg::CMD_SPIN_R, 16'd0, 32'd100, 1, 1);
    clock_ms = 100;
  endtask

  task automatic test_reset_config();
    send_random(200, 4'd15);
    calm = 1;
    send_random(80, 4'd15);
    calm = 0;
    drain();
  endtask

  task automatic test_extreme_config();
    write_reg(hhmd_pkg::REG_START_PWM, 16'd255);
    write_reg(hhmd_pkg::REG_RAMP_STEP, 16'd255);
    write_reg(hhmd_pkg::REG_RAMP_INTV, 16'd0);
    write_reg(hhmd_pkg::REG_KP_FWD, 16'hFFFF);
    write_reg(hhmd_pkg::REG_KD_FWD, 16'hFFFF);
    write_reg(hhmd_pkg::REG_KP_REV, 16'hFFFF);
    write_reg(hhmd_pkg::REG_KD_REV, 16'hFFFF);
    send_random(150, 4'd15);
    drain();
    write_reg(hhmd_pkg::REG_START_PWM, 16'd0);
    write_reg(hhmd_pkg::REG_RAMP_STEP, 16'd1);
    write_reg(hhmd_pkg::REG_RAMP_INTV, 16'hFFFF);
    write_reg(hhmd_pkg::REG_KP_FWD, 16'd0);
    write_reg(hhmd_pkg::REG_KD_FWD, 16'd0);
    write_reg(hhmd_pkg::REG_KP_REV, 16'd0);
    write_reg(hhmd_pkg::REG_KD_REV, 16'd0);
    send_random(100, 4'd15);
    drain();
  endtask

  task automatic test_random_config();
    write_reg(hhmd_pkg::REG_START_PWM, 16'($urandom_range(255)));
    write_reg(hhmd_pkg::REG_RAMP_STEP, 16'($urandom_range(255, 1)));
    write_reg(hhmd_pkg::REG_RAMP_INTV, 16'($urandom_range(15)));
    write_reg(hhmd_pkg::REG_KP_FWD, 16'($urandom));
    write_reg(hhmd_pkg::REG_KD_FWD, 16'($urandom));
    write_reg(hhmd_pkg::REG_KP_REV, 16'($urandom));
    write_reg(hhmd_pkg::REG_KD_REV, 16'($urandom));
    send_random(250, 4'd9);
    drain();
  endtask

  // result checker
  initial begin
    drive_word_t got, exp_w;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[19:0];
        if (expected_q.size() == 0) begin
          $error("unexpected word %h", m_axis_tdata);
          error_count++;
        end else begin
          exp_w = expected_q.pop_front();
          if (got.pwm_l !== exp_w.pwm_l) begin
            $error("pwm_left exp %0d got %0d", exp_w.pwm_l, got.pwm_l); error_count++;
          end
          if (got.pwm_r !== exp_w.pwm_r) begin
            $error("pwm_right exp %0d got %0d", exp_w.pwm_r, got.pwm_r); error_count++;
          end
          if (got.dir_l !== exp_w.dir_l) begin
            $error("dir_left exp %0d got %0d", exp_w.dir_l, got.dir_l); error_count++;
          end
          if (got.dir_r !== exp_w.dir_r) begin
            $error("dir_right exp %0d got %0d", exp_w.dir_r, got.dir_r); error_count++;
          end
          if (got.clr_drive !== exp_w.clr_drive) begin
            $error("clear_drive_boost exp %0d got %0d", exp_w.clr_drive, got.clr_drive);
            error_count++;
          end
          if (got.clr_turn !== exp_w.clr_turn) begin
            $error("clear_turn_boost exp %0d got %0d", exp_w.clr_turn, got.clr_turn);
            error_count++;
          end
        end
      end
      m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
    end
  end

  initial begin
    error_count = 0;
    calm = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = hhmd_pkg::REG_START_PWM;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    p_start_pwm = 8'd10; p_ramp_step = 8'd2; p_ramp_intv = 16'd8;
    p_kp_f = 16'd2621; p_kd_f = 16'd9830; p_kp_r = 16'd4588; p_kd_r = 16'd9830;
    tgt_heading = 0; prev_err = 0; prev_cmd = hhmd_pkg::CMD_STOP;
    duty_l = 0; duty_r = 0; dir_l = 0; dir_r = 0; ramp_t_l = 0; ramp_t_r = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain();
    test_reset_config();
    test_extreme_config();
    test_random_config();
    if (error_count == 0) begin
      $display("heading_hold_motor_drive_test: clean");
    end else begin
      $display("heading_hold_motor_drive_test: errors");
    end
    $finish;
  end

endmodule
